[hw/rtl/kcjp_pkg.sv]
// Shared types and constants for the joint position block.
`default_nettype none
package kcjp_pkg;
    localparam int unsigned WORD_W = 32;
    localparam logic [1:0] CFG_BASE_X = 2'd0;
    localparam logic [1:0] CFG_BASE_Y = 2'd1;
    localparam logic [1:0] CFG_BASE_Z = 2'd2;

    typedef struct packed {
        logic       start;     // latch item, begin row
        logic       clear_pp;  // row 0: zero partial product
        logic       load_id;   // first frame: identity
        logic [1:0] step;      // lane step 0..3 (matrix row i)
        logic       mac;       // do one row-i step of the outer product
        logic       commit;    // row 3: P -> A
        logic       pt_mac;    // point transform step
    } kcjp_cmd_t;

    typedef struct packed {
        logic       row_last;  // latched row_index == 3
    } kcjp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/kinematic_chain_joint_positions_top.sv]
// Top level of the serial-chain forward kinematics block.
// Usage:
//   in channel: one word per matrix row (row_index 0..3, col0..col3 in
//   signed Q16.16). first_frame on row 0 restarts from identity; the
//   result for a frame follows its row 3 word.
//   out channel: one word per frame: joint_index, pos_x/y/z, last_joint.
//   cfg channel: cfg_index 0..2 writes base_x/y/z; other indexes ignored.
// Sequence:
//   A row word is accepted, then takes four steps of the four lane
//   multipliers, one matrix row per step. A row 3 word adds a commit
//   step and four point-transform steps on the same multipliers, then
//   the result goes to the output register. A new row word is not
//   accepted until the block is done with the current one.
// Reset: accumulated transform is identity, partial product zero, joint
//   count zero, base point zero, output empty.
// Stall: a waiting result holds in the output register; the block keeps
//   accepting rows until the next result must be loaded.
`default_nettype none
module kinematic_chain_joint_positions_top
    import kcjp_pkg::*;
#(
    parameter int unsigned FRAC_BITS  = 16,
    parameter int unsigned MAX_JOINTS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               first_frame,
    input  wire logic               last_frame,
    input  wire logic [1:0]         row_index,
    input  wire logic signed [31:0] col0,
    input  wire logic signed [31:0] col1,
    input  wire logic signed [31:0] col2,
    input  wire logic signed [31:0] col3,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              joint_index,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic                    last_joint,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    localparam logic [3:0] CAP = (MAX_JOINTS - 1 < 15) ? 4'(MAX_JOINTS - 1) : 4'd15;

    kcjp_cmd_t cmd;
    kcjp_sts_t sts;
    logic out_load;
    logic signed [31:0] bx_reg, by_reg, bz_reg;
    logic signed [31:0] px, py, pz;
    logic [3:0] jc_reg;
    logic last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg <= '0;
            by_reg <= '0;
            bz_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_X: bx_reg <= cfg_data;
                CFG_BASE_Y: by_reg <= cfg_data;
                CFG_BASE_Z: bz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kcjp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .first_frame(first_frame), .row_index(row_index), .sts(sts),
        .out_busy(out_valid && !out_ready), .out_load(out_load), .cmd(cmd)
    );

    kcjp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .cmd(cmd), .row_index(row_index),
        .col0(col0), .col1(col1), .col2(col2), .col3(col3),
        .base_x(bx_reg), .base_y(by_reg), .base_z(bz_reg), .rst_n(rst_n),
        .sts(sts), .pos_x(px), .pos_y(py), .pos_z(pz)
    );

    // Joint count steps per result; last flag latched with the row word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jc_reg   <= 4'd0;
            last_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                last_reg <= last_frame;
                if (cmd.load_id)
                    jc_reg <= 4'd0;
            end
            if (out_load)
            begin
                out_valid <= 1'b1;
                if (last_reg)
                    jc_reg <= 4'd0;
                else if (jc_reg < CAP)
                    jc_reg <= jc_reg + 4'd1;
            end
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            joint_index <= (jc_reg > CAP) ? CAP : jc_reg;
            pos_x       <= px;
            pos_y       <= py;
            pos_z       <= pz;
            last_joint  <= last_reg;
        end
    end

    ast_cap: assert property (@(posedge clk) disable iff (!rst_n)
        jc_reg <= CAP) else $error("joint counter past cap");
    ast_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid) else $error("result lost");
    ast_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

[hw/rtl/kcjp_ctrl.sv]
// Controller sequencing the row steps and point transform.
`default_nettype none
module kcjp_ctrl
    import kcjp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      first_frame,
    input  wire logic [1:0] row_index,
    input  wire kcjp_sts_t sts,
    input  wire logic      out_busy,
    output logic           out_load,
    output kcjp_cmd_t      cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_COM  = 3'd2;
    localparam logic [2:0] S_PT   = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = (state_reg == S_IDLE);
        out_load   = 1'b0;
        cmd        = '0;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start    = 1'b1;
                    cmd.clear_pp = (row_index == 2'd0);
                    cmd.load_id  = (row_index == 2'd0) && first_frame;
                    cnt_next     = 2'd0;
                    state_next   = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac  = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = sts.row_last ? S_COM : S_IDLE;
            end
            S_COM:
            begin
                cmd.commit = 1'b1;
                cnt_next   = 2'd0;
                state_next = S_PT;
            end
            S_PT:
            begin
                cmd.pt_mac = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    ast_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_busy) else $error("load into busy output");
    ast_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac |-> !in_ready) else $error("ready during row work");
    ast_com_pt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> cmd.pt_mac) else $error("commit not followed by point");
endmodule
`default_nettype wire

[hw/rtl/kcjp_dp.sv]
// Datapath: matrices, four lane multipliers, point transform.
`default_nettype none
module kcjp_dp
    import kcjp_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire kcjp_cmd_t          cmd,
    input  wire logic [1:0]         row_index,
    input  wire logic signed [31:0] col0,
    input  wire logic signed [31:0] col1,
    input  wire logic signed [31:0] col2,
    input  wire logic signed [31:0] col3,
    input  wire logic signed [31:0] base_x,
    input  wire logic signed [31:0] base_y,
    input  wire logic signed [31:0] base_z,
    input  wire logic               rst_n,
    output kcjp_sts_t               sts,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z
);
    logic signed [31:0] a_reg [4][4];
    logic signed [31:0] p_reg [4][4];
    logic signed [31:0] row_reg [4];
    logic [1:0]         k_reg;
    logic signed [33:0] s_reg [3];
    logic signed [31:0] mb [4];
    logic signed [31:0] ma [4];
    logic signed [63:0] prod [4];
    logic signed [31:0] fm [4];
    logic signed [31:0] one_q;

    assign one_q = 32'sd1 <<< FRAC_BITS;
    assign sts.row_last = (k_reg == 2'd3);

    // Lane j: mac multiplies A[step][k] by F[k][j]; in a point step lane i
    // multiplies A[i][step] by base[step] for rows i = 0..2 (lane 3 idle).
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (cmd.pt_mac)
            begin
                ma[j] = (j < 3) ? a_reg[j][cmd.step] : 32'sd0;
                unique case (cmd.step)
                    2'd0: mb[j] = base_x;
                    2'd1: mb[j] = base_y;
                    2'd2: mb[j] = base_z;
                    default: mb[j] = 32'sd0;
                endcase
            end
            else
            begin
                ma[j] = a_reg[cmd.step][k_reg];
                mb[j] = row_reg[j];
            end
            prod[j] = ma[j] * mb[j];
            fm[j]   = sat32(66'(prod[j] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    a_reg[i][j] <= (i == j) ? one_q : 32'sd0;
                    p_reg[i][j] <= 32'sd0;
                end
            k_reg <= 2'd0;
        end
        else
        begin
            if (cmd.start)
            begin
                row_reg[0] <= col0;
                row_reg[1] <= col1;
                row_reg[2] <= col2;
                row_reg[3] <= col3;
                k_reg      <= row_index;
                if (cmd.load_id)
                    for (int i = 0; i < 4; i++)
                        for (int j = 0; j < 4; j++)
                            a_reg[i][j] <= (i == j) ? one_q : 32'sd0;
                if (cmd.clear_pp)
                    for (int i = 0; i < 4; i++)
                        for (int j = 0; j < 4; j++)
                            p_reg[i][j] <= 32'sd0;
            end
            if (cmd.mac)
                for (int j = 0; j < 4; j++)
                    p_reg[cmd.step][j] <= sat32(66'(p_reg[cmd.step][j])
                                                + 66'(fm[j]));
            if (cmd.commit)
                a_reg <= p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pt_mac)
            for (int i = 0; i < 3; i++)
                if (cmd.step == 2'd3)
                    s_reg[i] <= s_reg[i] + 34'(a_reg[i][3]);
                else if (cmd.step == 2'd0)
                    s_reg[i] <= 34'(fm[i]);
                else
                    s_reg[i] <= s_reg[i] + 34'(fm[i]);
    end

    assign pos_x = sat32(66'(s_reg[0]));
    assign pos_y = sat32(66'(s_reg[1]));
    assign pos_z = sat32(66'(s_reg[2]));
endmodule
`default_nettype wire
